@@ hdl/fnd_pkg.sv @@
// Shared types and constants for the fit-and-nearest downscaler.
// Holds configuration register indexes, field widths and the divider status.
// No dependencies.
`timescale 1ns / 1ps

package fnd_pkg;

    // Configuration port layout
    localparam int CFG_DATA_W  = 15;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_EDGE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_OPAQUE = 2'd3;

    // Register widths
    localparam int SRC_REG_W  = 15;
    localparam int EDGE_REG_W = 12;

    // Pixel samples
    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;

    // Reset values of the configuration registers
    localparam logic [SRC_REG_W-1:0]  SRC_SIZE_RESET = 15'd1;
    localparam logic [EDGE_REG_W-1:0] MAX_EDGE_RESET = 12'd2048;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hdl/fnd_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Shared by the output-size, row-select and column-select divisions.
// Depends on fnd_pkg for the status struct.
`timescale 1ns / 1ps

module fnd_divider #(
    parameter int N = 27,
    parameter int D = 15
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [N-1:0]     dividend,
    input  logic [D-1:0]     divisor,
    output logic [N-1:0]     quotient,
    output fnd_pkg::div_stat_t stat
);

    localparam int CW = (N > 1) ? $clog2(N) : 1;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [N-1:0]  q_reg;
    logic [D-1:0]  rem_reg;
    logic [D-1:0]  dvs_reg;

    logic [D:0]    shifted;
    logic [D:0]    diff;
    logic          ge;
    logic [D-1:0]  rem_step;

    // Trial subtraction for one quotient bit
    always_comb
    begin
        shifted  = {rem_reg, q_reg[N-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_step = ge ? diff[D-1:0] : shifted[D-1:0];
    end

    // Sequence the iterations
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(N - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Load operands, then shift quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[N-2:0], ge};
            rem_reg <= rem_step;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/fit_and_nearest_downscale_core.sv @@
// A pixel's result is registered as S_EMIT ends, after a row and a column division; ready
// returns on that edge, so a pixel is taken only once the last is through. A frame's first
// pixel adds S_SIZE, and a product and a division per edge when the size must be scaled.
// The shared bit-serial divider sets the time; a selected pixel waits in the final step
// while the output register is still full. Reset (rst_n, asynchronous, active low)
// restores the control and configuration registers and drops a waiting result.
`timescale 1ns / 1ps

module fit_and_nearest_downscale_core #(
    parameter int MAX_SOURCE_EDGE = 16384,
    parameter int MAX_OUTPUT_EDGE = 2048,
    localparam int OUT_W = $clog2(MAX_OUTPUT_EDGE + 1),
    localparam int POS_W = $clog2(MAX_OUTPUT_EDGE)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [fnd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fnd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // source pixels
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fnd_pkg::PIX_W-1:0]       red_in,
    input  logic [fnd_pkg::PIX_W-1:0]       green_in,
    input  logic [fnd_pkg::PIX_W-1:0]       blue_in,
    input  logic [fnd_pkg::PIX_W-1:0]       alpha_in,
    // output pixels
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fnd_pkg::PIX_W-1:0]       red_out,
    output logic [fnd_pkg::PIX_W-1:0]       green_out,
    output logic [fnd_pkg::PIX_W-1:0]       blue_out,
    output logic [fnd_pkg::PIX_W-1:0]       alpha_out,
    output logic [POS_W-1:0]                dest_x,
    output logic [POS_W-1:0]                dest_y,
    output logic [OUT_W-1:0]                dest_width,
    output logic [OUT_W-1:0]                dest_height,
    output logic                            last_pixel
);

    localparam int SRC_W = $clog2(MAX_SOURCE_EDGE + 1);
    localparam int SP_W  = $clog2(MAX_SOURCE_EDGE);
    localparam int ACC_W = SRC_W + OUT_W;
    localparam int DV_W  = (SRC_W > OUT_W) ? SRC_W : OUT_W;
    localparam int PW    = fnd_pkg::PIX_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SIZE     = 4'd1;
    localparam logic [3:0] S_SZ_MUL   = 4'd2;
    localparam logic [3:0] S_SZ_GO    = 4'd3;
    localparam logic [3:0] S_SZ_WAIT  = 4'd4;
    localparam logic [3:0] S_ROW_GO   = 4'd5;
    localparam logic [3:0] S_ROW_WAIT = 4'd6;
    localparam logic [3:0] S_COL_GO   = 4'd7;
    localparam logic [3:0] S_COL_WAIT = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    // Configuration registers
    logic [fnd_pkg::SRC_REG_W-1:0]  src_width_reg;
    logic [fnd_pkg::SRC_REG_W-1:0]  src_height_reg;
    logic [fnd_pkg::EDGE_REG_W-1:0] max_edge_reg;
    logic                           force_opaque_reg;

    // Control and position state
    logic [3:0]       state_reg,         state_next;
    logic             size_ready_reg,    size_ready_next;
    logic             half_reg,          half_next;
    logic             row_sel_reg,       row_sel_next;
    logic             col_sel_reg,       col_sel_next;
    logic [SP_W-1:0]  source_col_reg,    source_col_next;
    logic [SP_W-1:0]  source_row_reg,    source_row_next;
    logic [OUT_W-1:0] next_out_col_reg,  next_out_col_next;
    logic [OUT_W-1:0] next_out_row_reg,  next_out_row_next;
    logic [ACC_W-1:0] col_accum_reg,     col_accum_next;
    logic [ACC_W-1:0] row_accum_reg,     row_accum_next;
    logic [OUT_W-1:0] scaled_width_reg,  scaled_width_next;
    logic [OUT_W-1:0] scaled_height_reg, scaled_height_next;
    logic             out_valid_reg,     out_valid_next;

    // Payload registers
    logic [PW-1:0]    red_reg, green_reg, blue_reg, alpha_reg;
    logic [ACC_W-1:0] prod_reg;
    logic [PW-1:0]    red_out_reg, green_out_reg, blue_out_reg, alpha_out_reg;
    logic [POS_W-1:0] dest_x_reg, dest_y_reg;
    logic [OUT_W-1:0] dest_width_reg, dest_height_reg;
    logic             last_pixel_reg;

    // Datapath signals
    logic [31:0]      w_wide, h_wide, e_wide;
    logic [SRC_W-1:0] w, h, longest, mul_src;
    logic [OUT_W-1:0] e;
    logic [ACC_W-1:0] mul_res;
    logic [ACC_W-1:0] row_sum;
    logic             fits;
    logic             last_col, last_row;
    logic             emit, out_free, out_load, in_acc;
    logic [OUT_W-1:0] quot_clamp;

    // Divider interface
    logic               div_start;
    logic [ACC_W-1:0]   div_dividend;
    logic [DV_W-1:0]    div_divisor;
    logic [ACC_W-1:0]   div_quot;
    fnd_pkg::div_stat_t div_stat;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= fnd_pkg::SRC_SIZE_RESET;
            src_height_reg   <= fnd_pkg::SRC_SIZE_RESET;
            max_edge_reg     <= fnd_pkg::MAX_EDGE_RESET;
            force_opaque_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fnd_pkg::REG_SRC_WIDTH:
                    src_width_reg <= cfg_data[fnd_pkg::SRC_REG_W-1:0];
                fnd_pkg::REG_SRC_HEIGHT:
                    src_height_reg <= cfg_data[fnd_pkg::SRC_REG_W-1:0];
                fnd_pkg::REG_MAX_EDGE:
                    max_edge_reg <= cfg_data[fnd_pkg::EDGE_REG_W-1:0];
                fnd_pkg::REG_FORCE_OPAQUE:
                    force_opaque_reg <= cfg_data[0];
            endcase
        end
    end

    // Clamp the live source size and maximum edge
    always_comb
    begin
        w_wide = 32'(src_width_reg);
        if (src_width_reg == '0)
            w_wide = 32'd1;
        else if (w_wide > 32'(MAX_SOURCE_EDGE))
            w_wide = 32'(MAX_SOURCE_EDGE);
        h_wide = 32'(src_height_reg);
        if (src_height_reg == '0)
            h_wide = 32'd1;
        else if (h_wide > 32'(MAX_SOURCE_EDGE))
            h_wide = 32'(MAX_SOURCE_EDGE);
        e_wide = 32'(max_edge_reg);
        if (max_edge_reg == '0 || e_wide > 32'(MAX_OUTPUT_EDGE))
            e_wide = 32'(MAX_OUTPUT_EDGE);
        w       = w_wide[SRC_W-1:0];
        h       = h_wide[SRC_W-1:0];
        e       = e_wide[OUT_W-1:0];
        longest = (w > h) ? w : h;
        fits    = (32'(longest) <= e_wide);
    end

    // Scale products for the output size, one edge at a time
    assign mul_src = half_reg ? h : w;
    assign mul_res = ACC_W'(mul_src) * ACC_W'(e);

    assign row_sum    = row_accum_reg + ACC_W'(scaled_height_reg);
    assign last_col   = (SRC_W'(source_col_reg) >= (w - 1'b1));
    assign last_row   = (SRC_W'(source_row_reg) >= (h - 1'b1));
    assign quot_clamp = (div_quot == '0) ? OUT_W'(1) : div_quot[OUT_W-1:0];

    // Route operands to the shared divider
    always_comb
    begin
        div_start = (state_reg == S_SZ_GO) || (state_reg == S_ROW_GO) ||
                    (state_reg == S_COL_GO);
        priority if (state_reg == S_SZ_GO)
        begin
            div_dividend = prod_reg;
            div_divisor  = DV_W'(longest);
        end
        else if (state_reg == S_ROW_GO)
        begin
            div_dividend = row_sum;
            div_divisor  = DV_W'(h);
        end
        else
        begin
            div_dividend = col_accum_reg;
            div_divisor  = DV_W'(scaled_width_reg);
        end
    end

    fnd_divider #(
        .N (ACC_W),
        .D (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign emit     = row_sel_reg && col_sel_reg && (next_out_row_reg < scaled_height_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_EMIT) && emit && out_free;

    // Sequencer and position update
    always_comb
    begin
        state_next         = state_reg;
        size_ready_next    = size_ready_reg;
        half_next          = half_reg;
        row_sel_next       = row_sel_reg;
        col_sel_next       = col_sel_reg;
        source_col_next    = source_col_reg;
        source_row_next    = source_row_reg;
        next_out_col_next  = next_out_col_reg;
        next_out_row_next  = next_out_row_reg;
        col_accum_next     = col_accum_reg;
        row_accum_next     = row_accum_reg;
        scaled_width_next  = scaled_width_reg;
        scaled_height_next = scaled_height_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = size_ready_reg ? S_ROW_GO : S_SIZE;
            end
            S_SIZE:
            begin
                // Start of frame: clear position, keep or scale the size
                source_col_next   = '0;
                source_row_next   = '0;
                next_out_col_next = '0;
                next_out_row_next = '0;
                col_accum_next    = '0;
                row_accum_next    = '0;
                half_next         = 1'b0;
                if (fits)
                begin
                    scaled_width_next  = w[OUT_W-1:0];
                    scaled_height_next = h[OUT_W-1:0];
                    size_ready_next    = 1'b1;
                    state_next         = S_ROW_GO;
                end
                else
                begin
                    state_next = S_SZ_MUL;
                end
            end
            S_SZ_MUL:
                state_next = S_SZ_GO;
            S_SZ_GO:
                state_next = S_SZ_WAIT;
            S_SZ_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (!half_reg)
                    begin
                        scaled_width_next = quot_clamp;
                        half_next         = 1'b1;
                        state_next        = S_SZ_MUL;
                    end
                    else
                    begin
                        scaled_height_next = quot_clamp;
                        size_ready_next    = 1'b1;
                        state_next         = S_ROW_GO;
                    end
                end
            end
            S_ROW_GO:
                state_next = S_ROW_WAIT;
            S_ROW_WAIT:
            begin
                if (div_stat.done)
                begin
                    row_sel_next = last_row || (div_quot > ACC_W'(next_out_row_reg));
                    state_next   = S_COL_GO;
                end
            end
            S_COL_GO:
                state_next = S_COL_WAIT;
            S_COL_WAIT:
            begin
                if (div_stat.done)
                begin
                    col_sel_next = (next_out_col_reg < scaled_width_reg) &&
                                   (ACC_W'(source_col_reg) == div_quot);
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Hold while a selected pixel cannot enter the output register
                if (!emit || out_free)
                begin
                    if (emit)
                    begin
                        next_out_col_next = next_out_col_reg + 1'b1;
                        col_accum_next    = col_accum_reg + ACC_W'(w);
                    end
                    if (!last_col)
                    begin
                        source_col_next = source_col_reg + 1'b1;
                    end
                    else if (last_row)
                    begin
                        source_col_next   = '0;
                        source_row_next   = '0;
                        next_out_col_next = '0;
                        next_out_row_next = '0;
                        col_accum_next    = '0;
                        row_accum_next    = '0;
                        size_ready_next   = 1'b0;
                    end
                    else
                    begin
                        source_col_next   = '0;
                        next_out_col_next = '0;
                        col_accum_next    = '0;
                        if (row_sel_reg && (next_out_row_reg < scaled_height_reg))
                            next_out_row_next = next_out_row_reg + 1'b1;
                        row_accum_next  = row_sum;
                        source_row_next = source_row_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register: clear on take, set on load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            size_ready_reg    <= 1'b0;
            half_reg          <= 1'b0;
            row_sel_reg       <= 1'b0;
            col_sel_reg       <= 1'b0;
            source_col_reg    <= '0;
            source_row_reg    <= '0;
            next_out_col_reg  <= '0;
            next_out_row_reg  <= '0;
            col_accum_reg     <= '0;
            row_accum_reg     <= '0;
            scaled_width_reg  <= '0;
            scaled_height_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            size_ready_reg    <= size_ready_next;
            half_reg          <= half_next;
            row_sel_reg       <= row_sel_next;
            col_sel_reg       <= col_sel_next;
            source_col_reg    <= source_col_next;
            source_row_reg    <= source_row_next;
            next_out_col_reg  <= next_out_col_next;
            next_out_row_reg  <= next_out_row_next;
            col_accum_reg     <= col_accum_next;
            row_accum_reg     <= row_accum_next;
            scaled_width_reg  <= scaled_width_next;
            scaled_height_reg <= scaled_height_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Capture the pixel, the scale product and the result fields
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            alpha_reg <= alpha_in;
        end
        if (state_reg == S_SZ_MUL)
            prod_reg <= mul_res;
        if (out_load)
        begin
            red_out_reg     <= red_reg;
            green_out_reg   <= green_reg;
            blue_out_reg    <= blue_reg;
            alpha_out_reg   <= force_opaque_reg ? fnd_pkg::ALPHA_OPAQUE : alpha_reg;
            dest_x_reg      <= next_out_col_reg[POS_W-1:0];
            dest_y_reg      <= next_out_row_reg[POS_W-1:0];
            dest_width_reg  <= scaled_width_reg;
            dest_height_reg <= scaled_height_reg;
            last_pixel_reg  <= (next_out_col_reg == scaled_width_reg - 1'b1) &&
                               (next_out_row_reg == scaled_height_reg - 1'b1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_out     = red_out_reg;
    assign green_out   = green_out_reg;
    assign blue_out    = blue_out_reg;
    assign alpha_out   = alpha_out_reg;
    assign dest_x      = dest_x_reg;
    assign dest_y      = dest_y_reg;
    assign dest_width  = dest_width_reg;
    assign dest_height = dest_height_reg;
    assign last_pixel  = last_pixel_reg;

    // The divider is never restarted while it is still iterating
    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Row and column work only runs once the frame size is latched
    a_size_before_select: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW_GO || state_reg == S_COL_GO) |-> size_ready_reg)
        else $error("selection started without a latched size");

    // The output column never runs past the latched width
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_ready_reg |-> (next_out_col_reg <= scaled_width_reg))
        else $error("output column beyond output width");

    // A loaded result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // Acceptance closes the input side until the pixel is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("ready after acceptance");

endmodule
